@@ rtl/core/whist_pkg.sv @@
package whist_pkg;

    // Histogram size and derived widths.
    localparam int NUM_BINS = 128;
    localparam int BIN_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    // Wide enough for a 7-bit index, any bin index and NUM_BINS itself.
    localparam int EXT_W    = ((BIN_W > 7) ? BIN_W : 7) + 1;
    // The low 7 bits of the longest index only rise while every index fits.
    localparam bit LONGEST_MONO = (NUM_BINS <= 128);

    // Field widths of the stream payload.
    localparam int CH_W       = 8;
    localparam int IDX_W      = 7;
    localparam int COUNT_W    = 32;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    // Request kinds carried in the input tuser.
    localparam logic REQ_TEXT = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Separator bytes.
    localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CH_W-1:0] CH_NEWLINE = 8'h0A;

    typedef enum logic {
        ST_OUTSIDE,
        ST_INSIDE
    } t_word_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INC,
        OP_READ
    } t_op;

    // Decoded request handed from the word tracker to the bin store.
    typedef struct packed {
        t_op                op;
        logic [BIN_W-1:0]   addr;
        logic [IDX_W-1:0]   bin;
        logic               in_range;
    } t_req;

    // One result item.
    typedef struct packed {
        logic               word_done;
        logic [IDX_W-1:0]   bin;
        logic [COUNT_W-1:0] count;
        logic [IDX_W-1:0]   longest;
    } t_result;

endpackage

@@ rtl/core/whist_word_fsm.sv @@
module whist_word_fsm
    import whist_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_req_type,
    input  logic [CH_W-1:0]   i_ch,
    input  logic [IDX_W-1:0]  i_bin_index,
    output t_req              o_req
);

    t_word_state      r_state;
    t_word_state      n_state;
    logic [BIN_W-1:0] r_len;
    logic [BIN_W-1:0] n_len;
    logic             is_sep;
    logic [EXT_W-1:0] idx_ext;
    logic [EXT_W-1:0] len_ext;

    assign is_sep  = (i_ch == CH_SPACE) || (i_ch == CH_TAB) || (i_ch == CH_NEWLINE);
    assign idx_ext = EXT_W'(i_bin_index);
    assign len_ext = EXT_W'(r_len);

    // Next state and word length; read requests leave the tracker alone.
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        if (i_accept && (i_req_type == REQ_TEXT)) begin
            if (is_sep) begin
                n_state = ST_OUTSIDE;
                n_len   = '0;
            end else begin
                n_state = ST_INSIDE;
                if (r_len < BIN_W'(NUM_BINS - 1)) begin
                    n_len = r_len + 1'b1;
                end
            end
        end
    end

    // Request decode for the bin store.
    always_comb begin
        o_req.op       = OP_NONE;
        o_req.addr     = r_len;
        o_req.bin      = len_ext[IDX_W-1:0];
        o_req.in_range = 1'b1;
        if (i_req_type == REQ_READ) begin
            o_req.op       = OP_READ;
            o_req.addr     = idx_ext[BIN_W-1:0];
            o_req.bin      = i_bin_index;
            o_req.in_range = (idx_ext < EXT_W'(NUM_BINS));
        end else if (is_sep && (r_state == ST_INSIDE)) begin
            o_req.op = OP_INC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_OUTSIDE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
        end
    end

endmodule

@@ rtl/core/whist_bin_store.sv @@
module whist_bin_store
    import whist_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_vld,
    input  t_req    i_req,
    input  logic    i_adv,
    output logic    o_busy,
    output t_result o_result
);

    logic [COUNT_W-1:0] r_mem [NUM_BINS];
    logic [NUM_BINS-1:0] r_valid;
    logic [COUNT_W-1:0] r_rd_data;
    logic               r_rd_valid;
    logic               r_s1_vld;
    t_req               r_s1_req;
    logic               r_fwd_vld;
    logic [BIN_W-1:0]   r_fwd_addr;
    logic [COUNT_W-1:0] r_fwd_data;
    logic [BIN_W-1:0]   r_longest;
    logic [BIN_W-1:0]   n_longest;
    logic [COUNT_W-1:0] cur_count;
    logic [COUNT_W-1:0] n_count;
    logic               wr_en;
    logic [EXT_W-1:0]   longest_ext;

    assign o_busy = r_s1_vld;
    assign wr_en  = i_adv && (r_s1_req.op == OP_INC);

    // Memory: read at request time, write back when the stage moves on.
    always_ff @(posedge i_clk) begin
        if (i_req_vld) begin
            r_rd_data <= r_mem[i_req.addr];
        end
        if (wr_en) begin
            r_mem[r_s1_req.addr] <= n_count;
        end
    end

    // Written-bin flags stand in for clearing the memory at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[r_s1_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_vld) begin
            r_rd_valid <= r_valid[i_req.addr];
            r_s1_req   <= i_req;
        end
    end

    // The last write may have missed the read issued in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (wr_en) begin
            r_fwd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fwd_addr <= r_s1_req.addr;
            r_fwd_data <= n_count;
        end
    end

    // Stage occupancy and the longest nonzero bin.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_longest <= '0;
        end else begin
            if (i_req_vld) begin
                r_s1_vld <= 1'b1;
            end else if (i_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (i_adv) begin
                r_longest <= n_longest;
            end
        end
    end

    // Current count with forwarding, then saturating increment.
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_s1_req.addr)) begin
            cur_count = r_fwd_data;
        end else if (r_rd_valid) begin
            cur_count = r_rd_data;
        end else begin
            cur_count = '0;
        end
        n_count = (cur_count == '1) ? cur_count : cur_count + 1'b1;
    end

    always_comb begin
        n_longest = r_longest;
        if ((r_s1_req.op == OP_INC) && (r_s1_req.addr > r_longest)) begin
            n_longest = r_s1_req.addr;
        end
    end

    assign longest_ext = EXT_W'(n_longest);

    // Result assembly.
    always_comb begin
        o_result.word_done = 1'b0;
        o_result.bin       = '0;
        o_result.count     = '0;
        o_result.longest   = longest_ext[IDX_W-1:0];
        unique case (r_s1_req.op)
            OP_INC: begin
                o_result.word_done = 1'b1;
                o_result.bin       = r_s1_req.bin;
                o_result.count     = n_count;
            end
            OP_READ: begin
                o_result.bin   = r_s1_req.bin;
                o_result.count = r_s1_req.in_range ? cur_count : '0;
            end
            default: begin
                o_result.word_done = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/word_length_histogram_core.sv @@
// Word length histogram core.
// The slave channel takes one request per accepted transfer. i_s_tuser low marks
// a text byte in i_s_tdata[7:0]; i_s_tuser high asks for the count of the bin
// in i_s_tdata[14:8]. Space, tab and newline end a word, and a word that ends
// increments the bin for its length, the last bin taking every longer word.
// Counts saturate at all ones.
// Every request gives exactly one result on the master channel: o_m_tuser is
// the word-done flag, and o_m_tdata carries the bin, the new or read count and
// the highest bin holding a nonzero count.
// A request passes the memory stage, then the output register; one request per
// cycle is sustained while the receiver does not stall. The rate is set by the
// bin memory with one read port and one write port: one read-modify-write per
// cycle, with the last write forwarded to the next read of the same bin.
// Reset clears the word tracker, the longest-bin register and a flag per bin,
// so every bin reads as zero at once; no clearing pass is needed.
// When the receiver stalls, the result is held in the output register, one
// more request waits in the memory stage and the slave channel then stalls.
module word_length_histogram_core
    import whist_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,  // ch [7:0], bin_index [14:8], zero [15]
    input  logic                  i_s_tuser,  // req_type [0]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,  // bin [6:0], count [38:7], longest [45:39],
                                              // zero [47:46]
    output logic                  o_m_tuser   // word_done [0]
);

    logic    accept;
    logic    s1_busy;
    logic    s1_go;
    t_req    req;
    t_result s1_result;
    logic    r_out_vld;
    t_result r_out;

    // A request moves on when the output register is free or being emptied.
    assign s1_go      = s1_busy && (!r_out_vld || i_m_tready);
    assign o_s_tready = !s1_busy || s1_go;
    assign accept     = i_s_tvalid && o_s_tready;

    whist_word_fsm u_word_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req_type  (i_s_tuser),
        .i_ch        (i_s_tdata[CH_W-1:0]),
        .i_bin_index (i_s_tdata[CH_W+IDX_W-1:CH_W]),
        .o_req       (req)
    );

    whist_bin_store u_bin_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req_vld(accept),
        .i_req    (req),
        .i_adv    (s1_go),
        .o_busy   (s1_busy),
        .o_result (s1_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out <= s1_result;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out.word_done;
    assign o_m_tdata  = {2'b00, r_out.longest, r_out.count, r_out.bin};

endmodule

@@ rtl/core/whist_checker.sv @@
module whist_checker
    import whist_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [IN_DATA_W-1:0]  i_s_tdata,
    input logic                  i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tuser
);

    logic             r_seen;
    logic [IDX_W-1:0] r_last_longest;
    logic             out_req;

    assign out_req = o_m_tvalid && i_m_tready;

    // Longest bin of the last delivered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen         <= 1'b0;
            r_last_longest <= '0;
        end else if (out_req) begin
            r_seen         <= 1'b1;
            r_last_longest <= o_m_tdata[45:39];
        end
    end

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // A finished word always leaves a nonzero count behind.
    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> (o_m_tdata[38:7] != '0))
        else $error("word done with zero count");

    // The longest nonzero bin never shrinks from one result to the next.
    a_longest_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_seen && LONGEST_MONO |-> (o_m_tdata[45:39] >= r_last_longest))
        else $error("longest bin went down");

endmodule

bind word_length_histogram_core whist_checker u_whist_checker (.*);

@@ verif/word_length_histogram_core_tb.sv @@
module word_length_histogram_core_tb;
    import whist_pkg::*;

    localparam int TOTAL_REQUESTS = 1775;
    localparam int SETTLE_CYCLES  = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // ch [7:0], bin_index [14:8], zero [15]
    logic                  i_s_tuser;   // req_type [0]
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // bin [6:0], count [38:7], longest [45:39],
                                        // zero [47:46]
    logic                  o_m_tuser;   // word_done [0]

    // Mirror of the histogram: bin tallies, word tracker and the results they imply.
    class word_histogram_scoreboard;
        bit [COUNT_W-1:0] bin_tally[NUM_BINS];
        bit               in_word;
        int unsigned      word_len;
        int unsigned      longest_idx;
        t_result          pending_results[$];
        int unsigned      mismatches;

        function void note_request(logic req, logic [CH_W-1:0] ch, logic [IDX_W-1:0] idx);
            t_result     exp_r;
            int unsigned b;
            exp_r = '0;
            if (req == REQ_READ) begin
                exp_r.bin = idx;
                if (int'(idx) < NUM_BINS) begin
                    exp_r.count = bin_tally[idx];
                end
            end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_NEWLINE) begin
                // A separator closes any open word and files its length.
                if (in_word) begin
                    b = (word_len > NUM_BINS - 1) ? NUM_BINS - 1 : word_len;
                    if (bin_tally[b] != '1) begin
                        bin_tally[b]++;
                    end
                    if (bin_tally[b] != 0 && b > longest_idx) begin
                        longest_idx = b;
                    end
                    exp_r.word_done = 1'b1;
                    exp_r.bin       = IDX_W'(b);
                    exp_r.count     = bin_tally[b];
                end
                in_word  = 1'b0;
                word_len = 0;
            end else begin
                if (word_len < NUM_BINS - 1) begin
                    word_len++;
                end
                in_word = 1'b1;
            end
            exp_r.longest = IDX_W'(longest_idx);
            pending_results.push_back(exp_r);
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.word_done !== want.word_done) begin
                report("word_done", want.word_done, got.word_done);
            end
            if (got.bin !== want.bin) report("bin", want.bin, got.bin);
            if (got.count !== want.count) report("count", want.count, got.count);
            if (got.longest !== want.longest) report("longest", want.longest, got.longest);
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    word_histogram_scoreboard hist_sb;
    int unsigned              req_sent;
    int unsigned              res_seen;
    bit                       src_eager;
    bit                       snk_eager;

    word_length_histogram_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Clock with a period of ten time units.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Both handshakes are observed on the same edge: requests first, then results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                hist_sb.note_request(i_s_tuser, i_s_tdata[CH_W-1:0],
                                     i_s_tdata[CH_W+IDX_W-1:CH_W]);
            end
            if (o_m_tvalid && i_m_tready) begin
                hist_sb.check_result('{word_done: o_m_tuser,
                                       bin:       o_m_tdata[IDX_W-1:0],
                                       count:     o_m_tdata[IDX_W+COUNT_W-1:IDX_W],
                                       longest:   o_m_tdata[2*IDX_W+COUNT_W-1:IDX_W+COUNT_W]});
            end
        end
    end

    // Result receiver: stalls a random number of cycles before each result,
    // with stretches of no stalling at all.
    initial begin
        int stall;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (res_seen % 50 == 0) begin
                snk_eager = ($urandom_range(0, 2) == 0);
            end
            stall = snk_eager ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
            res_seen++;
        end
    end

    // Offers one request, after a random gap, and waits for it to be taken.
    task automatic send_request(input logic req, input logic [CH_W-1:0] ch,
                                input logic [IDX_W-1:0] idx);
        int gap;
        if (req_sent % 64 == 0) begin
            src_eager = ($urandom_range(0, 2) == 0);
        end
        gap = src_eager ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, idx, ch};
        i_s_tuser  <= req;
        do @(posedge i_clk); while (!o_s_tready);
        req_sent++;
    endtask

    // The unused field of each request carries random bits.
    task automatic send_text(input logic [CH_W-1:0] ch);
        send_request(REQ_TEXT, ch, IDX_W'($urandom_range(0, 127)));
    endtask

    task automatic send_read(input logic [IDX_W-1:0] idx);
        send_request(REQ_READ, CH_W'($urandom_range(0, 255)), idx);
    endtask

    function automatic logic [CH_W-1:0] random_letter();
        logic [CH_W-1:0] c;
        do c = CH_W'($urandom_range(0, 255));
        while (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE);
        return c;
    endfunction

    function automatic logic [CH_W-1:0] random_separator();
        case ($urandom_range(0, 2))
            0: return CH_SPACE;
            1: return CH_TAB;
            default: return CH_NEWLINE;
        endcase
    endfunction

    task automatic send_word(input int len);
        for (int i = 0; i < len; i++) begin
            send_text(random_letter());
        end
    endtask

    initial begin
        int pick;
        int len;
        hist_sb    = new();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = REQ_TEXT;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty store at both ends of the index range.
        send_read(7'd0);
        send_read(7'd127);
        // A separator with no word before it.
        send_text(CH_SPACE);
        // Word made of the extreme byte values, closed by a tab.
        send_text(8'h00);
        send_text(8'hFF);
        send_text(CH_TAB);
        // One-byte word closed by a newline.
        send_text(8'h41);
        send_text(CH_NEWLINE);
        // A read in the middle of a word must leave the word intact.
        send_text(8'h78);
        send_text(8'h79);
        send_read(7'd2);
        send_text(8'h7A);
        send_text(CH_SPACE);
        // A run of separators closes nothing further.
        send_text(CH_SPACE);
        send_text(CH_TAB);
        send_text(CH_NEWLINE);
        // Bytes next to the separator codes count as word bytes.
        send_text(8'h08);
        send_text(8'h0B);
        send_text(8'h1F);
        send_text(8'h21);
        send_text(CH_SPACE);
        send_read(7'd3);
        send_read(7'd4);

        // Mostly well-formed text with random words, some very long, plus
        // reads and stray bytes.
        while (req_sent < TOTAL_REQUESTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_read(($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 15))
                                                      : IDX_W'($urandom_range(0, 127)));
            end else if (pick < 16) begin
                send_text(CH_W'($urandom_range(0, 255)));
            end else begin
                len = ($urandom_range(0, 39) == 0) ? $urandom_range(120, 140)
                                                   : $urandom_range(1, 12);
                send_word(len);
                send_text(random_separator());
                if ($urandom_range(0, 7) == 0) begin
                    send_text(random_separator());
                end
            end
        end
        // Read back the top bins, then leave a word open at the end of input.
        send_read(7'd126);
        send_read(7'd127);
        send_word(5);
        i_s_tvalid <= 1'b0;

        while (hist_sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (hist_sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/whist_pkg.sv
rtl/core/whist_word_fsm.sv
rtl/core/whist_bin_store.sv
rtl/core/word_length_histogram_core.sv
rtl/core/whist_checker.sv
verif/word_length_histogram_core_tb.sv
